// File: hdl/gvsu_pkg.sv
package gvsu_pkg;

  localparam logic [15:0] TS_RESET = 16'd4096;

  // Digit counts of the iterative units, one digit per pipeline stage.
  localparam int FF_DIV_STEPS  = 32;
  localparam int FF_SQRT_STEPS = 24;
  localparam int CG_DIV_STEPS  = 44;
  localparam int CG_SQRT_STEPS = 32;

  // Register stages of each path, counted from the input ports.
  localparam int FF_LAT     = FF_DIV_STEPS + FF_SQRT_STEPS + 6;
  localparam int CG_LAT     = CG_DIV_STEPS + CG_SQRT_STEPS + 7;
  localparam int PIPE_DEPTH = CG_LAT;
  localparam int FF_PAD     = PIPE_DEPTH - FF_LAT;

  typedef logic signed [41:0] ff_t;

  typedef struct packed {
    logic        active;
    logic [24:0] speed;
  } cg_res_t;

  localparam ff_t OUT_MAX = 42'sd65535;
  localparam ff_t OUT_MIN = -42'sd65536;

endpackage

// File: hdl/gipps_vehicle_speed_update.sv
// Gipps car-following speed update, one vehicle per word.
// The input channel takes one vehicle's data per word with in_valid and
// in_stall; the output channel returns new_speed and free_flow with
// out_valid and out_stall. time_step is written through cfg_write and
// cfg_data and should only change while no word is in flight.
// Every accepted word gives exactly one result word, in order. The
// congested path is the longer one and sets the depth of the pipeline,
// with a 44-digit divider for the leader braking term and a 32-digit
// square root, one digit per stage; the free-flow path is padded to match.
// With the output taken freely the block accepts one word every cycle.
// When the receiver stalls, one more result lands in a skid register and
// in_stall then rises, freezing the whole pipeline until the output
// moves again; nothing is dropped or repeated.
// Reset empties the pipeline and the output stage and sets time_step to
// one second.
module gipps_vehicle_speed_update
  import gvsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        own_speed,
  input  logic [15:0]        own_max_speed,
  input  logic [15:0]        lane_speed_limit,
  input  logic               lane_known,
  input  logic [12:0]        max_accel,
  input  logic [12:0]        own_decel,
  input  logic [15:0]        standstill_gap,
  input  logic               leader_present,
  input  logic [23:0]        leader_gap,
  input  logic [15:0]        leader_speed,
  input  logic [15:0]        leader_length,
  input  logic [12:0]        leader_decel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] new_speed,
  output logic               free_flow
);

  logic [15:0]           ts;
  logic                  en;
  logic                  push;
  logic                  skid_v;
  logic [PIPE_DEPTH-1:0] vld;
  ff_t                   ffv;
  cg_res_t               cg;

  always_ff @(posedge clk) begin
    if (rst) begin
      ts <= TS_RESET;
    end else if (cfg_write) begin
      ts <= cfg_data;
    end
  end

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign push     = en && vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid};
    end
  end

  gvsu_free u_free (
    .clk              (clk),
    .en               (en),
    .ts               (ts),
    .own_speed        (own_speed),
    .own_max_speed    (own_max_speed),
    .lane_speed_limit (lane_speed_limit),
    .lane_known       (lane_known),
    .max_accel        (max_accel),
    .ff_speed         (ffv)
  );

  gvsu_cong u_cong (
    .clk            (clk),
    .en             (en),
    .ts             (ts),
    .own_speed      (own_speed),
    .own_decel      (own_decel),
    .standstill_gap (standstill_gap),
    .leader_present (leader_present),
    .leader_gap     (leader_gap),
    .leader_speed   (leader_speed),
    .leader_length  (leader_length),
    .leader_decel   (leader_decel),
    .cg_res         (cg)
  );

  // The congested speed wins only when strictly below the free-flow speed.
  ff_t         cgx, sel;
  logic        take_cg;
  logic [16:0] res_speed;
  assign cgx     = ff_t'($signed(cg.speed));
  assign take_cg = cg.active && (cgx < ffv);
  assign sel     = take_cg ? cgx : ffv;

  always_comb begin
    if (sel > OUT_MAX) begin
      res_speed = OUT_MAX[16:0];
    end else if (sel < OUT_MIN) begin
      res_speed = OUT_MIN[16:0];
    end else begin
      res_speed = sel[16:0];
    end
  end

  logic [16:0] skid_speed;
  logic        skid_ff;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (!out_stall) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && out_stall) begin
        skid_v <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!out_stall) begin
        new_speed <= $signed(skid_speed);
        free_flow <= skid_ff;
      end
    end else if (push) begin
      if (out_valid && out_stall) begin
        skid_speed <= res_speed;
        skid_ff    <= !take_cg;
      end else begin
        new_speed <= $signed(res_speed);
        free_flow <= !take_cg;
      end
    end
  end

  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_valid)
    else $error("skid register holds a word while the output is empty");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled output");

  a_push_lands : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(push)) |-> out_valid)
    else $error("pipeline result did not reach the output");

endmodule

// File: hdl/gvsu_free.sv
module gvsu_free
  import gvsu_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] ts,
  input  logic [15:0] own_speed,
  input  logic [15:0] own_max_speed,
  input  logic [15:0] lane_speed_limit,
  input  logic        lane_known,
  input  logic [12:0] max_accel,
  output ff_t         ff_speed
);

  typedef struct packed {
    logic [15:0] v;
    logic        zero;
    logic [28:0] at;
  } div_side_t;

  typedef struct packed {
    logic [15:0] v;
    logic        zero;
    logic [28:0] at;
    logic        dneg;
    logic [31:0] dmag;
  } rt_side_t;

  logic [15:0] cap_in;
  assign cap_in = (own_max_speed < lane_speed_limit) ? own_max_speed : lane_speed_limit;

  // Ratio v/V in Q16 by restoring division.
  logic [15:0] drem  [0:FF_DIV_STEPS];
  logic [31:0] dacc  [0:FF_DIV_STEPS];
  logic [15:0] dden  [0:FF_DIV_STEPS];
  div_side_t   dside [0:FF_DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]       <= '0;
      dacc[0]       <= {own_speed, 16'h0000};
      dden[0]       <= cap_in;
      dside[0].v    <= own_speed;
      dside[0].zero <= !lane_known || (cap_in == 16'd0);
      dside[0].at   <= 29'(max_accel) * 29'(ts);
    end
  end

  for (genvar i = 1; i <= FF_DIV_STEPS; i++) begin : g_div
    logic [16:0] trial;
    logic        take;
    assign trial = {drem[i-1], dacc[i-1][31]};
    assign take  = trial >= {1'b0, dden[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        drem[i]  <= take ? 16'(trial - {1'b0, dden[i-1]}) : trial[15:0];
        dacc[i]  <= {dacc[i-1][30:0], take};
        dden[i]  <= dden[i-1];
        dside[i] <= dside[i-1];
      end
    end
  end

  logic [31:0] r;
  assign r = dacc[FF_DIV_STEPS];

  // Square root of (r + 0.025) in Q16.
  logic [47:0] srad  [0:FF_SQRT_STEPS];
  logic [25:0] srem  [0:FF_SQRT_STEPS];
  logic [23:0] sroot [0:FF_SQRT_STEPS];
  rt_side_t    sside [0:FF_SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      srad[0]       <= {r + 32'd1638, 16'h0000};
      srem[0]       <= '0;
      sroot[0]      <= '0;
      sside[0].v    <= dside[FF_DIV_STEPS].v;
      sside[0].zero <= dside[FF_DIV_STEPS].zero;
      sside[0].at   <= dside[FF_DIV_STEPS].at;
      sside[0].dneg <= r > 32'd65536;
      sside[0].dmag <= (r > 32'd65536) ? r - 32'd65536 : 32'd65536 - r;
    end
  end

  for (genvar j = 1; j <= FF_SQRT_STEPS; j++) begin : g_sqrt
    logic [27:0] cat;
    logic [27:0] trial;
    logic        take;
    assign cat   = {srem[j-1], srad[j-1][47:46]};
    assign trial = {2'b00, sroot[j-1], 2'b01};
    assign take  = cat >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem[j]  <= take ? 26'(cat - trial) : cat[25:0];
        sroot[j] <= {sroot[j-1][22:0], take};
        srad[j]  <= {srad[j-1][45:0], 2'b00};
        sside[j] <= sside[j-1];
      end
    end
  end

  rt_side_t    sfin;
  logic [55:0] mprod;
  assign sfin  = sside[FF_SQRT_STEPS];
  assign mprod = 56'(sfin.dmag) * 56'(sroot[FF_SQRT_STEPS]);

  logic [39:0] m;
  logic [31:0] k;
  logic [15:0] v_m, v_p, v_s;
  logic        zero_m, zero_p, zero_s;
  logic        dneg_m, dneg_p, dneg_s;
  logic [51:0] pl, ph;
  logic [71:0] p;

  always_ff @(posedge clk) begin
    if (en) begin
      m      <= mprod[55:16];
      k      <= 32'({sfin.at, 2'b00}) + 32'(sfin.at);
      v_m    <= sfin.v;
      zero_m <= sfin.zero;
      dneg_m <= sfin.dneg;
      // The 32 x 40 product is cut into two partial products.
      pl     <= 52'(k) * 52'(m[19:0]);
      ph     <= 52'(k) * 52'(m[39:20]);
      v_p    <= v_m;
      zero_p <= zero_m;
      dneg_p <= dneg_m;
      p      <= (72'(ph) << 20) + 72'(pl);
      v_s    <= v_p;
      zero_s <= zero_p;
      dneg_s <= dneg_p;
    end
  end

  logic [40:0] delta;
  ff_t         vs, dx, ff_c;
  assign delta = (|p[71:64]) ? (41'd1 << 40) : {6'b0, p[63:29]};
  assign vs    = $signed({26'b0, v_s});
  assign dx    = $signed({1'b0, delta});
  assign ff_c  = zero_s ? '0 : (dneg_s ? vs - dx : vs + dx);

  // Delay so that the result lines up with the congested path.
  ff_t pad [0:FF_PAD];

  always_ff @(posedge clk) begin
    if (en) begin
      pad[0] <= ff_c;
      for (int i = 1; i <= FF_PAD; i++) begin
        pad[i] <= pad[i-1];
      end
    end
  end

  assign ff_speed = pad[FF_PAD];

endmodule

// File: hdl/gvsu_cong.sv
module gvsu_cong
  import gvsu_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] ts,
  input  logic [15:0] own_speed,
  input  logic [12:0] own_decel,
  input  logic [15:0] standstill_gap,
  input  logic        leader_present,
  input  logic [23:0] leader_gap,
  input  logic [15:0] leader_speed,
  input  logic [15:0] leader_length,
  input  logic [12:0] leader_decel,
  output cg_res_t     cg_res
);

  typedef struct packed {
    logic [12:0] d;
    logic        dlnz;
    logic        active;
    logic [24:0] f;
    logic [49:0] f2;
    logic [39:0] x0;
  } div_side_t;

  typedef struct packed {
    logic [24:0] f;
    logic        active;
    logic        neg;
  } rt_side_t;

  logic [12:0] d1, dl1;
  logic        act1;
  logic [29:0] fraw1;
  logic [25:0] gd1;
  logic [31:0] vt1, vl2_1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= own_decel;
      dl1   <= leader_decel;
      act1  <= leader_present && (own_decel != 13'd0);
      fraw1 <= 30'(own_decel) * 30'(17'(ts) + 17'd8192);
      gd1   <= 26'(leader_gap) - 26'(leader_length) - 26'(standstill_gap);
      vt1   <= 32'(own_speed) * 32'(ts);
      vl2_1 <= 32'(leader_speed) * 32'(leader_speed);
    end
  end

  logic [24:0]        f_c;
  logic [49:0]        f2_c;
  logic signed [39:0] x0_c;
  assign f_c  = fraw1[29:5];
  assign f2_c = 50'(f_c) * 50'(f_c);
  assign x0_c = (40'($signed(gd1)) <<< 13) - $signed(40'(vt1));

  // Leader braking term vl^2 / Dl by restoring division.
  logic [12:0] qrem  [0:CG_DIV_STEPS];
  logic [43:0] qacc  [0:CG_DIV_STEPS];
  logic [12:0] qden  [0:CG_DIV_STEPS];
  div_side_t   qside [0:CG_DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      qrem[0]         <= '0;
      qacc[0]         <= {vl2_1, 12'h000};
      qden[0]         <= dl1;
      qside[0].d      <= d1;
      qside[0].dlnz   <= dl1 != 13'd0;
      qside[0].active <= act1;
      qside[0].f      <= f_c;
      qside[0].f2     <= f2_c;
      qside[0].x0     <= x0_c;
    end
  end

  for (genvar i = 1; i <= CG_DIV_STEPS; i++) begin : g_div
    logic [13:0] trial;
    logic        take;
    assign trial = {qrem[i-1], qacc[i-1][43]};
    assign take  = trial >= {1'b0, qden[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        qrem[i]  <= take ? 13'(trial - {1'b0, qden[i-1]}) : trial[12:0];
        qacc[i]  <= {qacc[i-1][42:0], take};
        qden[i]  <= qden[i-1];
        qside[i] <= qside[i-1];
      end
    end
  end

  div_side_t          qs;
  logic signed [45:0] x_c;
  assign qs  = qside[CG_DIV_STEPS];
  assign x_c = 46'($signed(qs.x0))
             + (qs.dlnz ? $signed({2'b00, qacc[CG_DIV_STEPS]}) : 46'sd0);

  logic signed [45:0] x;
  logic [12:0]        d_x;
  logic [24:0]        f_x, f_y, f_z;
  logic [49:0]        f2_x, f2_y, f2_z;
  logic               act_x, act_y, act_z;
  logic [35:0]        pl;
  logic signed [36:0] ph;
  logic signed [58:0] dx;

  always_ff @(posedge clk) begin
    if (en) begin
      x     <= x_c;
      d_x   <= qs.d;
      f_x   <= qs.f;
      f2_x  <= qs.f2;
      act_x <= qs.active;
      // D times X as a low unsigned and a high signed partial product.
      pl    <= 36'(d_x) * 36'(x[22:0]);
      ph    <= $signed({1'b0, d_x}) * $signed(x[45:23]);
      f_y   <= f_x;
      f2_y  <= f2_x;
      act_y <= act_x;
      dx    <= (59'(ph) <<< 23) + $signed(59'(pl));
      f_z   <= f_y;
      f2_z  <= f2_y;
      act_z <= act_y;
    end
  end

  logic signed [63:0] c_c;
  assign c_c = $signed(64'(f2_z)) + (64'(dx) <<< 4);

  // Square root of the radicand; a negative radicand goes through as zero.
  logic [63:0] crad  [0:CG_SQRT_STEPS];
  logic [33:0] crem  [0:CG_SQRT_STEPS];
  logic [31:0] croot [0:CG_SQRT_STEPS];
  rt_side_t    cside [0:CG_SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      crad[0]         <= c_c[63] ? '0 : c_c;
      crem[0]         <= '0;
      croot[0]        <= '0;
      cside[0].f      <= f_z;
      cside[0].active <= act_z;
      cside[0].neg    <= c_c[63];
    end
  end

  for (genvar j = 1; j <= CG_SQRT_STEPS; j++) begin : g_sqrt
    logic [35:0] cat;
    logic [35:0] trial;
    logic        take;
    assign cat   = {crem[j-1], crad[j-1][63:62]};
    assign trial = {2'b00, croot[j-1], 2'b01};
    assign take  = cat >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        crem[j]  <= take ? 34'(cat - trial) : cat[33:0];
        croot[j] <= {croot[j-1][30:0], take};
        crad[j]  <= {crad[j-1][61:0], 2'b00};
        cside[j] <= cside[j-1];
      end
    end
  end

  rt_side_t           cs;
  logic signed [32:0] diff;
  logic signed [32:0] diff_sh;
  assign cs      = cside[CG_SQRT_STEPS];
  assign diff    = $signed({1'b0, croot[CG_SQRT_STEPS]}) - $signed({8'b0, cs.f});
  assign diff_sh = diff >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      cg_res.active <= cs.active;
      cg_res.speed  <= cs.neg ? '0 : diff_sh[24:0];
    end
  end

endmodule

// File: test/tb.sv
module tb;
  import gvsu_pkg::*;

  typedef struct {
    logic [15:0] own_speed;
    logic [15:0] own_max_speed;
    logic [15:0] lane_speed_limit;
    logic        lane_known;
    logic [12:0] max_accel;
    logic [12:0] own_decel;
    logic [15:0] standstill_gap;
    logic        leader_present;
    logic [23:0] leader_gap;
    logic [15:0] leader_speed;
    logic [15:0] leader_length;
    logic [12:0] leader_decel;
  } vehicle_t;

  typedef struct {
    logic signed [16:0] speed;
    logic               ff;
  } speed_word_t;

  class speed_scoreboard;
    logic [15:0] ts = TS_RESET;
    speed_word_t pending_speeds[$];
    int errors = 0;

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint free_speed(vehicle_t it);
      longint unsigned cap, r, s, m, k, dmag, delta, t;
      longint d;
      t = ts;
      cap = (it.own_max_speed < it.lane_speed_limit) ? it.own_max_speed : it.lane_speed_limit;
      if (!it.lane_known || cap == 0) return 0;
      r = (longint'(it.own_speed) << 16) / cap;
      d = 65536 - longint'(r);
      s = int_sqrt((r + 1638) << 16);
      dmag = (d >= 0) ? d : -d;
      m = (dmag * s) >> 16;
      k = 5 * longint'(it.max_accel) * t;
      // The product would wrap, so the step is forced large enough to saturate.
      if (k != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / k) delta = 64'd1 << 40;
      else delta = (k * m) >> 29;
      if (d >= 0) return longint'(it.own_speed) + longint'(delta);
      return longint'(it.own_speed) - longint'(delta);
    endfunction

    function longint congested_speed(vehicle_t it);
      longint c, f, x, content, t, dec;
      t = ts;
      dec = it.own_decel;
      c = t + 8192;
      f = (dec * c) >>> 5;
      x = 2 * (longint'(it.leader_gap) - longint'(it.leader_length)
               - longint'(it.standstill_gap)) * 4096;
      x = x - longint'(it.own_speed) * t;
      if (it.leader_decel != 0)
        x = x + ((longint'(it.leader_speed) * longint'(it.leader_speed)) << 12)
                / longint'(it.leader_decel);
      content = f * f + 16 * (dec * x);
      if (content < 0) return 0;
      return (longint'(int_sqrt(content)) - f) >>> 8;
    endfunction

    function void note_vehicle(vehicle_t it);
      longint sp, cg;
      speed_word_t w;
      sp = free_speed(it);
      w.ff = 1'b1;
      if (it.leader_present && it.own_decel != 0) begin
        cg = congested_speed(it);
        if (cg < sp) begin
          sp = cg;
          w.ff = 1'b0;
        end
      end
      if (sp > 65535) sp = 65535;
      if (sp < -65536) sp = -65536;
      w.speed = sp[16:0];
      pending_speeds.push_back(w);
    endfunction

    function void check_speed(logic signed [16:0] sp, logic ff);
      speed_word_t w;
      if (pending_speeds.size() == 0) begin
        $display("%0t: result word with none expected: speed %0d ff %0b", $time, sp, ff);
        errors++;
        return;
      end
      w = pending_speeds.pop_front();
      if (sp !== w.speed) begin
        $display("%0t: new_speed expected %0d actual %0d", $time, w.speed, sp);
        errors++;
      end
      if (ff !== w.ff) begin
        $display("%0t: free_flow expected %0b actual %0b", $time, w.ff, ff);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] own_speed = '0;
  logic [15:0] own_max_speed = '0;
  logic [15:0] lane_speed_limit = '0;
  logic lane_known = 1'b0;
  logic [12:0] max_accel = '0;
  logic [12:0] own_decel = '0;
  logic [15:0] standstill_gap = '0;
  logic leader_present = 1'b0;
  logic [23:0] leader_gap = '0;
  logic [15:0] leader_speed = '0;
  logic [15:0] leader_length = '0;
  logic [12:0] leader_decel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] new_speed;
  logic free_flow;

  speed_scoreboard sb = new();
  int hold_request = 0;
  int idle_cycles = 0;

  gipps_vehicle_speed_update dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .own_speed(own_speed), .own_max_speed(own_max_speed),
    .lane_speed_limit(lane_speed_limit), .lane_known(lane_known),
    .max_accel(max_accel), .own_decel(own_decel),
    .standstill_gap(standstill_gap), .leader_present(leader_present),
    .leader_gap(leader_gap), .leader_speed(leader_speed),
    .leader_length(leader_length), .leader_decel(leader_decel),
    .out_valid(out_valid), .out_stall(out_stall),
    .new_speed(new_speed), .free_flow(free_flow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Scoreboard taps and watchdog.
  always @(posedge clk) begin
    vehicle_t it;
    if (cfg_write) sb.ts = cfg_data;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid && !in_stall) begin
        it.own_speed = own_speed;
        it.own_max_speed = own_max_speed;
        it.lane_speed_limit = lane_speed_limit;
        it.lane_known = lane_known;
        it.max_accel = max_accel;
        it.own_decel = own_decel;
        it.standstill_gap = standstill_gap;
        it.leader_present = leader_present;
        it.leader_gap = leader_gap;
        it.leader_speed = leader_speed;
        it.leader_length = leader_length;
        it.leader_decel = leader_decel;
        sb.note_vehicle(it);
      end
      if (out_valid && !out_stall) sb.check_speed(new_speed, free_flow);
      if (idle_cycles > IDLE_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: a stall pattern that changes mode every so often, plus a long hold on request.
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  task automatic drive_vehicle(vehicle_t it);
    own_speed <= it.own_speed;
    own_max_speed <= it.own_max_speed;
    lane_speed_limit <= it.lane_speed_limit;
    lane_known <= it.lane_known;
    max_accel <= it.max_accel;
    own_decel <= it.own_decel;
    standstill_gap <= it.standstill_gap;
    leader_present <= it.leader_present;
    leader_gap <= it.leader_gap;
    leader_speed <= it.leader_speed;
    leader_length <= it.leader_length;
    leader_decel <= it.leader_decel;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sends words in bursts: after each word, perhaps a gap.
  task automatic send_vehicle(vehicle_t it);
    drive_vehicle(it);
    if ($urandom_range(0, 5) == 0) idle_input($urandom_range(1, 12));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_speeds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_time_step(logic [15:0] value);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic vehicle_t quiet_vehicle();
    vehicle_t it;
    it.own_speed = 16'd5120;
    it.own_max_speed = 16'd7680;
    it.lane_speed_limit = 16'd8960;
    it.lane_known = 1'b1;
    it.max_accel = 13'd512;
    it.own_decel = 13'd1024;
    it.standstill_gap = 16'd512;
    it.leader_present = 1'b1;
    it.leader_gap = 24'd10240;
    it.leader_speed = 16'd4096;
    it.leader_length = 16'd1024;
    it.leader_decel = 13'd1024;
    return it;
  endfunction

  function automatic vehicle_t random_vehicle();
    vehicle_t it;
    int cap;
    if ($urandom_range(0, 9) < 3) begin
      it.own_speed = 16'($urandom());
      it.own_max_speed = 16'($urandom());
      it.lane_speed_limit = 16'($urandom());
      it.lane_known = 1'($urandom());
      it.max_accel = 13'($urandom());
      it.own_decel = 13'($urandom());
      it.standstill_gap = 16'($urandom());
      it.leader_present = 1'($urandom());
      it.leader_gap = 24'($urandom());
      it.leader_speed = 16'($urandom());
      it.leader_length = 16'($urandom());
      it.leader_decel = 13'($urandom());
    end else begin
      cap = $urandom_range(1280, 15360);
      it.own_max_speed = 16'(cap);
      it.lane_speed_limit = 16'(cap + $urandom_range(0, 2000));
      if ($urandom_range(0, 1)) begin
        it.own_max_speed = it.lane_speed_limit;
        it.lane_speed_limit = 16'(cap);
      end
      it.own_speed = 16'($urandom_range(0, cap + cap / 4));
      it.lane_known = ($urandom_range(0, 15) != 0);
      it.max_accel = 13'($urandom_range(128, 1024));
      it.own_decel = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(256, 2560));
      it.standstill_gap = 16'($urandom_range(256, 1280));
      it.leader_present = ($urandom_range(0, 7) != 0);
      it.leader_gap = 24'($urandom_range(0, 256 * 200));
      it.leader_speed = 16'($urandom_range(0, cap));
      it.leader_length = 16'($urandom_range(768, 4096));
      it.leader_decel = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom_range(256, 2560));
    end
    return it;
  endfunction

  task automatic run_directed();
    vehicle_t it;
    it = quiet_vehicle();
    send_vehicle(it);
    // All fields at zero, then all at their maximum.
    it = '{default: '0};
    send_vehicle(it);
    it = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 13'h1FFF, 13'h1FFF, 16'hFFFF,
           1'b1, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF};
    send_vehicle(it);
    it = quiet_vehicle(); it.lane_known = 1'b0; send_vehicle(it);
    it = quiet_vehicle(); it.own_max_speed = 0; send_vehicle(it);
    it = quiet_vehicle(); it.lane_speed_limit = 0; it.leader_present = 0; send_vehicle(it);
    it = quiet_vehicle(); it.leader_present = 1'b0; send_vehicle(it);
    it = quiet_vehicle(); it.own_decel = 0; it.leader_gap = 0; send_vehicle(it);
    it = quiet_vehicle(); it.leader_decel = 0; send_vehicle(it);
    // A leader closer than its own length makes the radicand negative.
    it = quiet_vehicle(); it.leader_gap = 0; it.leader_length = 16'hFFFF;
    it.standstill_gap = 16'hFFFF; it.leader_decel = 0; send_vehicle(it);
    it = quiet_vehicle(); it.own_speed = 16'hFFFF; it.own_max_speed = 16'd1;
    it.max_accel = 13'h1FFF; it.leader_present = 0; send_vehicle(it);
    it = quiet_vehicle(); it.own_speed = 0; it.leader_gap = 24'hFFFFFF; send_vehicle(it);
    it = quiet_vehicle(); it.own_speed = 16'd7680; it.lane_speed_limit = 16'd7680;
    send_vehicle(it);
    it = quiet_vehicle(); it.own_decel = 13'd1; it.leader_decel = 13'h1FFF;
    it.leader_speed = 16'hFFFF; send_vehicle(it);
    it = quiet_vehicle(); it.max_accel = 0; it.leader_gap = 24'd2000; send_vehicle(it);
  endtask

  task automatic run_random(int count);
    repeat (count) send_vehicle(random_vehicle());
  endtask

  initial begin
    vehicle_t big;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(90);
    write_time_step(16'hFFFF);
    // The largest step with a tiny speed cap overflows the free-flow step.
    big = quiet_vehicle();
    big.own_speed = 16'hFFFF; big.own_max_speed = 16'd1; big.max_accel = 13'h1FFF;
    send_vehicle(big);
    big.leader_present = 1'b0;
    send_vehicle(big);
    run_directed();
    run_random(80);
    write_time_step(16'd1);
    run_directed();
    run_random(80);
    write_time_step(16'($urandom_range(1, 16'hFFFF)));
    // Hold the output off for a long stretch while words keep arriving.
    hold_request = LONG_HOLD;
    run_random(110);
    write_time_step(16'd2048);
    run_random(110);
    drain_results();
    if (sb.errors == 0 && sb.pending_speeds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
